// ----- rtl/gsig_pkg.sv -----
// ----------------------------------------------------------------------------
// gsig_pkg: shared types and constants for the grid strip index generator
// Holds the tile count limits and the decoded configuration bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package gsig_pkg;

  localparam int unsigned TileW  = 8;
  localparam int unsigned IndexW = 16;
  localparam int unsigned CountW = 17;

  localparam logic [TileW-1:0] MaxTiles   = 8'd255;
  localparam logic [TileW-1:0] ResetTiles = 8'd1;

  // decoded configuration: effective tile count and total strip length
  typedef struct packed {
    logic [TileW-1:0]  tiles;
    logic [CountW-1:0] idx_count;
  } cfg_t;

endpackage

`default_nettype wire

// ----- rtl/grid_strip_index_generator_core.sv -----
// ----------------------------------------------------------------------------
// grid_strip_index_generator_core: triangle strip indices for an N x N grid
// Emits one vertex index per transfer for a single strip with degenerate
// joins between rows; marks the final index and reports the strip length.
// ----------------------------------------------------------------------------
//
//  channel | signals                               | dir | notes
//  --------+---------------------------------------+-----+----------------------
//  in      | in_valid_i, in_ready_o, restart_i     | in  | restart=1 -> first idx
//  out     | out_valid_o, out_ready_i,             | out | one result per input
//          | vertex_index_o, last_o, index_count_o |     |
//  cfg     | cfg_we_i, cfg_wdata_i                 | in  | tile count, no wait
//
//  Each input transfer yields its result from the output register in the
//  cycle after; one transfer per cycle is sustained while out_ready_i is
//  high, set by the single counter update between the input and the result
//  register. The result register accepts a new transfer in the cycle it is drained.
//  Reset (async, active low) sets the tile count to 1 and the sequence to
//  its first index; a cfg write also restarts the sequence.
//  A stall on out_ready_i holds the result and deasserts in_ready_o.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_strip_index_generator_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // configuration
  input  wire logic                         cfg_we_i,
  input  wire logic [gsig_pkg::TileW-1:0]   cfg_wdata_i,
  // input channel
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic                         restart_i,
  // output channel
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [gsig_pkg::IndexW-1:0]       vertex_index_o,
  output logic                              last_o,
  output logic [gsig_pkg::CountW-1:0]       index_count_o
);

  typedef enum logic [2:0] {
    PhDupStart = 3'd0,
    PhStart    = 3'd1,
    PhLower    = 3'd2,
    PhUpper    = 3'd3,
    PhEnd      = 3'd4,
    PhDupEnd   = 3'd5
  } phase_e;

  gsig_pkg::cfg_t cfg;

  gsig_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  // strip position
  phase_e                        phase_q, phase_d;
  logic [gsig_pkg::TileW-1:0]    row_q, row_d;
  logic [gsig_pkg::TileW-1:0]    column_q, column_d;
  logic [gsig_pkg::IndexW-1:0]   row_base_q, row_base_d;

  // result register
  logic                          out_valid_q;
  logic [gsig_pkg::IndexW-1:0]   vertex_index_q, vertex_index_d;
  logic                          last_q, last_d;
  logic [gsig_pkg::CountW-1:0]   index_count_q;

  // position after an optional restart
  phase_e                        phase_s;
  logic [gsig_pkg::TileW-1:0]    row_s, column_s, column_inc;
  logic [gsig_pkg::IndexW-1:0]   row_base_s, verts_per_row, next_base;
  logic [gsig_pkg::TileW:0]      row_inc;

  logic in_xfer;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    phase_s    = restart_i ? PhStart : phase_q;
    row_s      = restart_i ? '0 : row_q;
    column_s   = restart_i ? '0 : column_q;
    row_base_s = restart_i ? '0 : row_base_q;

    verts_per_row = {{(gsig_pkg::IndexW-gsig_pkg::TileW){1'b0}}, cfg.tiles} + 16'd1;
    next_base     = row_base_s + verts_per_row;
    row_inc       = {1'b0, row_s} + 9'd1;
    column_inc    = column_s + 8'd1;

    phase_d        = phase_s;
    row_d          = row_s;
    column_d       = column_s;
    row_base_d     = row_base_s;
    vertex_index_d = row_base_s;
    last_d         = 1'b0;

    case (phase_s)
      PhDupStart: begin
        phase_d = PhStart;
      end
      PhLower: begin
        vertex_index_d = next_base
                       + {{(gsig_pkg::IndexW-gsig_pkg::TileW){1'b0}}, column_s};
        phase_d = PhUpper;
      end
      PhUpper: begin
        vertex_index_d = row_base_s
                       + {{(gsig_pkg::IndexW-gsig_pkg::TileW){1'b0}}, column_inc};
        column_d = column_inc;
        phase_d  = (column_inc >= cfg.tiles) ? PhEnd : PhLower;
      end
      PhEnd: begin
        vertex_index_d = next_base
                       + {{(gsig_pkg::IndexW-gsig_pkg::TileW){1'b0}}, cfg.tiles};
        if (row_inc >= {1'b0, cfg.tiles}) begin
          // final index: wrap to the top of the strip
          last_d     = 1'b1;
          phase_d    = PhStart;
          row_d      = '0;
          column_d   = '0;
          row_base_d = '0;
        end else begin
          phase_d = PhDupEnd;
        end
      end
      PhDupEnd: begin
        vertex_index_d = next_base
                       + {{(gsig_pkg::IndexW-gsig_pkg::TileW){1'b0}}, cfg.tiles};
        row_d      = row_inc[gsig_pkg::TileW-1:0];
        row_base_d = next_base;
        column_d   = '0;
        phase_d    = PhDupStart;
      end
      default: begin
        // row start; unused codes behave the same
        column_d = '0;
        phase_d  = PhLower;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PhStart;
      row_q          <= '0;
      column_q       <= '0;
      row_base_q     <= '0;
      out_valid_q    <= 1'b0;
      vertex_index_q <= '0;
      last_q         <= 1'b0;
      index_count_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        // new tile count: start over
        phase_q    <= PhStart;
        row_q      <= '0;
        column_q   <= '0;
        row_base_q <= '0;
      end else if (in_xfer) begin
        phase_q    <= phase_d;
        row_q      <= row_d;
        column_q   <= column_d;
        row_base_q <= row_base_d;
      end
      if (in_xfer) begin
        out_valid_q    <= 1'b1;
        vertex_index_q <= vertex_index_d;
        last_q         <= last_d;
        index_count_q  <= cfg.idx_count;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign vertex_index_o = vertex_index_q;
  assign last_o         = last_q;
  assign index_count_o  = index_count_q;

  // cfg write always leaves the strip at its first index
  a_cfg_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> (phase_q == PhStart && row_q == '0 && column_q == '0
                  && row_base_q == '0))
    else $error("position not cleared after cfg write");

  // position counters stay inside the grid
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (column_q <= cfg.tiles) && (row_q < cfg.tiles))
    else $error("strip position outside grid");

  // a restart transfer yields vertex 0, never the final index
  a_restart_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && restart_i) |=> (out_valid_o && vertex_index_o == '0 && !last_o))
    else $error("restart did not emit first index");

endmodule

`default_nettype wire

// ----- rtl/gsig_cfg.sv -----
// ----------------------------------------------------------------------------
// gsig_cfg: tile count register
// Clamps the written tile count and precomputes the strip length 2N*N+4N-2.
// ----------------------------------------------------------------------------
`default_nettype none

module gsig_cfg (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        we_i,
  input  wire logic [gsig_pkg::TileW-1:0]  wdata_i,
  output gsig_pkg::cfg_t                   cfg_o
);

  gsig_pkg::cfg_t cfg_d, cfg_q;
  logic [2*gsig_pkg::TileW-1:0] sq;

  always_comb begin
    cfg_d.tiles = wdata_i;
    if (wdata_i == '0) begin
      cfg_d.tiles = gsig_pkg::ResetTiles;
    end else if (wdata_i > gsig_pkg::MaxTiles) begin
      cfg_d.tiles = gsig_pkg::MaxTiles;
    end
    sq = cfg_d.tiles * cfg_d.tiles;
    // 2*N*N + 4*N - 2, at most 131068
    cfg_d.idx_count = {sq, 1'b0}
                    + {{(gsig_pkg::CountW-gsig_pkg::TileW-2){1'b0}}, cfg_d.tiles, 2'b00}
                    - 17'd2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tiles     <= gsig_pkg::ResetTiles;
      cfg_q.idx_count <= 17'd4;
    end else if (we_i) begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire
